// ----- rtl/tof_hit_time_calibration_core_defines.svh -----
// Assertion macros for the calibration core
`ifndef TOF_HIT_TIME_CALIBRATION_CORE_DEFINES_SVH
`define TOF_HIT_TIME_CALIBRATION_CORE_DEFINES_SVH
`ifndef SYNTH
`define THC_ASSERT_SAME(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("calibration core check failed");
`define THC_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("calibration core check failed");
`else
`define THC_ASSERT_SAME(lbl, a, c)
`define THC_ASSERT_NEXT(lbl, a, c)
`endif
`endif

// ----- rtl/thc_pkg.sv -----
`timescale 1ns / 1ps
package thc_pkg;
  localparam int NUM_STATIONS = 3;
  localparam int MAX_SLABS = 10;
  localparam int ADC_BITS = 14;
  localparam int NUM_CHANNELS = NUM_STATIONS * 2 * MAX_SLABS * 2;
  localparam int NUM_PIXELS = MAX_SLABS * MAX_SLABS;
  localparam int CH_W = $clog2(NUM_CHANNELS);
  localparam int PIX_W = $clog2(NUM_PIXELS);
  localparam int DIV_W = 48;
  localparam int DIVR_W = 32;

  typedef enum logic [2:0] {
    OP_HIT = 3'd0, OP_T0 = 3'd1, OP_P0 = 3'd2, OP_P1 = 3'd3,
    OP_P2 = 3'd4, OP_P3 = 3'd5, OP_PIX = 3'd6, OP_NOP = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    CFG_EN_T0 = 2'd0, CFG_EN_WALK = 2'd1, CFG_EN_DELAY = 2'd2, CFG_TRIG_ST = 2'd3
  } cfg_idx_t;

  function automatic int slab_count(logic [1:0] st);
    case (st)
      2'd0: slab_count = 10;
      2'd1: slab_count = 7;
      2'd2: slab_count = 10;
      default: slab_count = 10;
    endcase
  endfunction

  function automatic logic chan_ok(logic [1:0] st, logic [3:0] sl);
    chan_ok = (int'(st) < NUM_STATIONS) && (int'(sl) < MAX_SLABS) &&
              (int'(sl) < slab_count(st));
  endfunction

  function automatic logic [CH_W-1:0] chan_index(logic [1:0] st, logic pl,
                                                 logic [3:0] sl, logic pm);
    chan_index = CH_W'((((int'(st) * 2 + int'(pl)) * MAX_SLABS + int'(sl)) * 2)
                       + int'(pm));
  endfunction

  function automatic logic [PIX_W-1:0] pixel_index(logic [3:0] x, logic [3:0] y);
    pixel_index = PIX_W'(int'(x) * MAX_SLABS + int'(y));
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [47:0] v);
    if (v > 48'sd2147483647) sat32 = 32'sh7fffffff;
    else if (v < -48'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [47:0] v);
    if (v > 48'sd32767) sat16 = 16'sh7fff;
    else if (v < -48'sd32768) sat16 = 16'sh8000;
    else sat16 = v[15:0];
  endfunction

  function automatic logic signed [47:0] sat48(logic signed [51:0] v);
    if (v > 52'sd140737488355327) sat48 = 48'sh7fffffffffff;
    else if (v < -52'sd140737488355328) sat48 = 48'sh800000000000;
    else sat48 = v[47:0];
  endfunction
endpackage

// ----- rtl/thc_if.sv -----
`timescale 1ns / 1ps
interface thc_hit_if;
  logic valid;
  logic ready;
  logic [2:0] op;
  logic [1:0] station;
  logic plane;
  logic [3:0] slab;
  logic pmt;
  logic [13:0] adc;
  logic [1:0] pixel_station;
  logic [3:0] pixel_x;
  logic [3:0] pixel_y;
  logic signed [47:0] value;
  logic [3:0] ref_slab_in;
  modport source (output valid, op, station, plane, slab, pmt, adc, pixel_station,
                  pixel_x, pixel_y, value, ref_slab_in, input ready);
  modport sink (input valid, op, station, plane, slab, pmt, adc, pixel_station,
                pixel_x, pixel_y, value, ref_slab_in, output ready);
endinterface

interface thc_res_if;
  logic valid;
  logic ready;
  logic signed [47:0] time_correction;
  logic valid_res;
  modport source (output valid, time_correction, valid_res, input ready);
  modport sink (input valid, time_correction, valid_res, output ready);
endinterface

interface thc_cfg_if;
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/tof_hit_time_calibration_core.sv -----
`timescale 1ns / 1ps
// Time-of-flight hit calibration core.
// Channels: hit (sink) carries hits (op 0) and table writes (ops 1..6, op 7
// ignored); res (source) returns one beat per hit; cfg (sink) writes the
// enable bits and the trigger station, always ready; the user must write it
// only while idle, which the block does not enforce.
// Throughput: one beat per cycle on hit while hit.ready is high, writes and
// hits freely mixed; a write is seen by every hit accepted after it.
// Pipeline: a hit passes three lookup and arithmetic stages (the first
// loaded at the accepting edge), a 48-stage divider pair (one bit of
// quotient per stage) for p2/x and p3/x^2, and the output register.
// Channel tables sit in 120-entry memories and pixel delays in a 100-entry
// memory with two read ports; each pixel carries a valid flop.
// Reset (rst, synchronous) empties the pipeline, clears the pixel valid flops,
// restores the enables to 1 and the trigger station to 0, and starts a pass
// that zeroes the channel tables; hit.ready stays low until that pass ends.
// When res is stalled the whole pipeline holds and hit.ready drops; nothing
// is lost or repeated.
`include "tof_hit_time_calibration_core_defines.svh"
module tof_hit_time_calibration_core (
  input logic clk,
  input logic rst,
  thc_hit_if.sink hit,
  thc_res_if.source res,
  thc_cfg_if.sink cfg
);
  localparam int NC = thc_pkg::NUM_CHANNELS;
  localparam int NP = thc_pkg::NUM_PIXELS;
  localparam int CW = thc_pkg::CH_W;
  localparam int PW = thc_pkg::PIX_W;
  localparam int DL = thc_pkg::DIV_W;

  logic en_t0, en_walk, en_delay;
  logic [1:0] trig_st;

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      en_t0 <= 1'b1;
      en_walk <= 1'b1;
      en_delay <= 1'b1;
      trig_st <= 2'd0;
    end else if (cfg.valid) begin
      case (cfg.index)
        thc_pkg::CFG_EN_T0: en_t0 <= cfg.data[0];
        thc_pkg::CFG_EN_WALK: en_walk <= cfg.data[0];
        thc_pkg::CFG_EN_DELAY: en_delay <= cfg.data[0];
        thc_pkg::CFG_TRIG_ST: trig_st <= cfg.data[1:0];
        default: ;
      endcase
    end
  end

  // zero the channel tables after reset
  logic clr_busy;
  logic [CW-1:0] clr_idx;
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_idx <= '0;
    end else if (clr_busy) begin
      if (clr_idx == CW'(NC - 1)) clr_busy <= 1'b0;
      clr_idx <= clr_idx + 1'b1;
    end
  end

  logic adv, acc;
  assign adv = !res.valid || res.ready;
  assign hit.ready = adv && !clr_busy;
  assign acc = hit.valid && hit.ready;

  logic ch_ok, pix_ok;
  logic [CW-1:0] ch;
  logic [PW-1:0] pa1;
  assign ch_ok = thc_pkg::chan_ok(hit.station, hit.slab);
  assign ch = ch_ok ? thc_pkg::chan_index(hit.station, hit.plane, hit.slab, hit.pmt) : '0;
  assign pix_ok = (hit.pixel_station == trig_st) &&
                  (int'(hit.pixel_station) < thc_pkg::NUM_STATIONS) &&
                  (int'(hit.pixel_x) < thc_pkg::MAX_SLABS) &&
                  (int'(hit.pixel_y) < thc_pkg::MAX_SLABS);
  assign pa1 = pix_ok ? thc_pkg::pixel_index(hit.pixel_x, hit.pixel_y) : '0;

  logic signed [31:0] t0_mem [NC];
  logic [3:0]         ref_mem [NC];
  logic signed [15:0] p0_mem [NC];
  logic signed [31:0] p1_mem [NC];
  logic signed [47:0] p2_mem [NC];
  logic signed [47:0] p3_mem [NC];
  logic signed [31:0] pd_mem [NP];
  logic [NP-1:0] pix_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_vld <= '0;
    end else if (acc && pix_ok && hit.op == thc_pkg::OP_PIX) begin
      pix_vld[pa1] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      t0_mem[clr_idx] <= '0;
      ref_mem[clr_idx] <= '0;
      p0_mem[clr_idx] <= '0;
      p1_mem[clr_idx] <= '0;
      p2_mem[clr_idx] <= '0;
      p3_mem[clr_idx] <= '0;
    end else if (acc && ch_ok) begin
      case (hit.op)
        thc_pkg::OP_T0: begin
          t0_mem[ch] <= thc_pkg::sat32(hit.value);
          ref_mem[ch] <= hit.ref_slab_in;
        end
        thc_pkg::OP_P0: p0_mem[ch] <= thc_pkg::sat16(hit.value);
        thc_pkg::OP_P1: p1_mem[ch] <= thc_pkg::sat32(hit.value);
        thc_pkg::OP_P2: p2_mem[ch] <= hit.value;
        thc_pkg::OP_P3: p3_mem[ch] <= hit.value;
        default: ;
      endcase
    end
    if (acc && pix_ok && hit.op == thc_pkg::OP_PIX) pd_mem[pa1] <= thc_pkg::sat32(hit.value);
  end

  // stage 1: table lookups
  logic v1, ok1_ch, trig1, plane1, pv1;
  logic [3:0] sl1;
  logic [13:0] adc1;
  logic signed [31:0] t0_1, p1_1, pd1_1;
  logic [3:0] ref1;
  logic signed [15:0] p0_1;
  logic signed [47:0] p2_1, p3_1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= acc && hit.op == thc_pkg::OP_HIT;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok1_ch <= ch_ok;
      trig1 <= hit.station == trig_st;
      plane1 <= hit.plane;
      sl1 <= hit.slab;
      adc1 <= 14'(hit.adc[thc_pkg::ADC_BITS-1:0]);
      t0_1 <= t0_mem[ch];
      ref1 <= ref_mem[ch];
      p0_1 <= p0_mem[ch];
      p1_1 <= p1_mem[ch];
      p2_1 <= p2_mem[ch];
      p3_1 <= p3_mem[ch];
      pv1 <= pix_ok && pix_vld[pa1];
      pd1_1 <= pd_mem[pa1];
    end
  end

  // stage 2: offset adc, reference pixel lookup, partial sum
  logic ref_ok;
  logic [PW-1:0] pa2;
  assign ref_ok = int'(ref1) < thc_pkg::MAX_SLABS;
  assign pa2 = !ref_ok ? '0 : (plane1 ? thc_pkg::pixel_index(ref1, sl1)
                                      : thc_pkg::pixel_index(sl1, ref1));

  logic v2, ok2, trig2, pv2;
  logic signed [17:0] x2;
  logic signed [33:0] base2;
  logic signed [31:0] pd2_2;
  logic signed [47:0] p2_2, p3_2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ok2 <= ok1_ch && (!en_t0 || t0_1 != 0) &&
             (!en_walk || (p0_1 != 0 && p1_1 != 0 && p2_1 != 0 && p3_1 != 0)) &&
             (!en_delay || pv1);
      trig2 <= trig1;
      x2 <= $signed({4'b0, adc1}) + 18'(p0_1);
      base2 <= (en_t0 ? 34'(t0_1) : 34'sd0) - (en_walk ? 34'(p1_1) : 34'sd0)
               - (en_delay ? 34'(pd1_1) : 34'sd0);
      pv2 <= ref_ok && trig1 && pix_vld[pa2];
      pd2_2 <= pd_mem[pa2];
      p2_2 <= p2_1;
      p3_2 <= p3_1;
    end
  end

  // stage 3: square, magnitudes, final validity
  typedef struct packed {
    logic v;
    logic ok;
    logic neg2;
    logic neg3;
    logic signed [34:0] base;
  } side_t;

  logic [15:0] xmag;
  logic use_walk;
  assign xmag = x2[17] ? 16'(-x2) : x2[15:0];
  assign use_walk = en_walk && x2 != 0;

  side_t s3;
  logic [DL-1:0] dnd2, dnd3;
  logic [31:0] dvs2, dvs3;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3 <= '0;
    end else if (adv) begin
      s3.v <= v2;
      s3.ok <= ok2 && (!en_walk || x2 != 0) && (!en_delay || !trig2 || pv2);
      s3.neg2 <= p2_2[47] ^ x2[17];
      s3.neg3 <= p3_2[47];
      s3.base <= 35'(base2) + ((en_delay && trig2) ? 35'(pd2_2) : 35'sd0);
      dnd2 <= use_walk ? (p2_2[47] ? DL'(-p2_2) : DL'(p2_2)) : '0;
      dnd3 <= use_walk ? (p3_2[47] ? DL'(-p3_2) : DL'(p3_2)) : '0;
      dvs2 <= use_walk ? 32'(xmag) : 32'd1;
      dvs3 <= use_walk ? 32'(xmag) * 32'(xmag) : 32'd1;
    end
  end

  logic [DL-1:0] q2, q3;
  thc_div u_div_lin (.clk(clk), .en(adv), .dividend(dnd2), .divisor(dvs2), .quotient(q2));
  thc_div u_div_quad (.clk(clk), .en(adv), .dividend(dnd3), .divisor(dvs3), .quotient(q3));

  side_t side [DL];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DL; i++) side[i].v <= 1'b0;
    end else if (adv) begin
      side[0] <= s3;
      for (int i = 1; i < DL; i++) side[i] <= side[i-1];
    end
  end

  side_t last;
  logic signed [51:0] sum;
  assign last = side[DL-1];
  assign sum = 52'(last.base) - (last.neg2 ? -52'($signed({1'b0, q2})) : 52'({1'b0, q2}))
               - (last.neg3 ? -52'($signed({1'b0, q3})) : 52'({1'b0, q3}));

  always_ff @(posedge clk) begin
    if (rst) res.valid <= 1'b0;
    else if (adv) res.valid <= last.v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.valid_res <= last.ok;
      res.time_correction <= last.ok ? thc_pkg::sat48(sum) : '0;
    end
  end

  `THC_ASSERT_SAME(a_invalid_zero, res.valid && !res.valid_res, res.time_correction == 0)
  `THC_ASSERT_SAME(a_stall_blocks, res.valid && !res.ready, !hit.ready)
  `THC_ASSERT_NEXT(a_write_no_result, hit.valid && hit.ready && hit.op != thc_pkg::OP_HIT, !v1)
endmodule

// ----- rtl/thc_div.sv -----
`timescale 1ns / 1ps
module thc_div (
  input  logic clk,
  input  logic en,
  input  logic [thc_pkg::DIV_W-1:0] dividend,
  input  logic [thc_pkg::DIVR_W-1:0] divisor,
  output logic [thc_pkg::DIV_W-1:0] quotient
);
  localparam int N = thc_pkg::DIV_W;
  localparam int D = thc_pkg::DIVR_W;

  logic [D:0]   rem [N];
  logic [N-1:0] num [N];
  logic [N-1:0] quo [N];
  logic [D-1:0] dvs [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [D:0]   rem_in;
    logic [N-1:0] num_in;
    logic [N-1:0] quo_in;
    logic [D-1:0] dvs_in;
    logic [D:0]   trial;
    logic         ge;
    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = dividend;
      assign quo_in = '0;
      assign dvs_in = divisor;
    end else begin : g_next
      assign rem_in = rem[k-1];
      assign num_in = num[k-1];
      assign quo_in = quo[k-1];
      assign dvs_in = dvs[k-1];
    end
    assign trial = {rem_in[D-1:0], num_in[N-1]};
    assign ge = trial >= {1'b0, dvs_in};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? trial - {1'b0, dvs_in} : trial;
        num[k] <= {num_in[N-2:0], 1'b0};
        quo[k] <= {quo_in[N-2:0], ge};
        dvs[k] <= dvs_in;
      end
    end
  end

  assign quotient = quo[N-1];
endmodule
